FILE: hw/rtl/kra_pkg.sv
// Package for the keyed reading aggregator: field widths, character codes,
// result kinds and the statistics entry type. No dependencies.
package kra_pkg;

  localparam int INDEX_BITS = 12;
  localparam int TABLE_SIZE = 1 << INDEX_BITS;

  localparam int HASH_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int RIDX_W  = 12;
  localparam int CNT_W   = 32;
  localparam int SUM_W   = 48;
  localparam int EXT_W   = 12;
  localparam int ACC_W   = 11;
  localparam int ACCX_W  = 15;

  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 120;
  localparam int M_PAD_W  = M_DATA_W - (RIDX_W + CNT_W + SUM_W + 2 * EXT_W);

  localparam logic [HASH_W-1:0] HASH_BASE_RESET = 32'd113;
  localparam logic [ACC_W-1:0]  ACC_MAX         = 11'd2047;
  localparam logic [CNT_W-1:0]  CNT_MAX         = '1;
  localparam logic signed [SUM_W-1:0] SUM_MAX   = {1'b0, {(SUM_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN   = {1'b1, {(SUM_W - 1){1'b0}}};
  localparam logic signed [EXT_W-1:0] MIN_RESET = {1'b0, {(EXT_W - 1){1'b1}}};
  localparam logic signed [EXT_W-1:0] MAX_RESET = {1'b1, {(EXT_W - 1){1'b0}}};

  localparam logic [BYTE_W-1:0] CHAR_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  typedef enum logic {
    MODE_TEXT = 1'b0,
    MODE_READ = 1'b1
  } mode_e;

  typedef enum logic {
    KIND_UPDATE = 1'b0,
    KIND_READ   = 1'b1
  } kind_e;

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [SUM_W-1:0] sum;
    logic signed [EXT_W-1:0] min;
    logic signed [EXT_W-1:0] max;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{count: '0, sum: '0, min: MIN_RESET, max: MAX_RESET};

endpackage

FILE: hw/rtl/keyed_reading_aggregator_top.sv
// Keyed reading aggregator: line parser, name hash, statistics table with
// read-modify-write update and read replies. Depends on kra_pkg.
//
// Pipeline: a request that yields a result passes the stage 1 input register,
// the stage 2 read data register and the output register. Throughput: one
// request per cycle unless the output stalls, set by the table read in stage 1
// and write-back with forwarding in stage 2. Reset: a clearing pass writes all
// 4096 table entries, one per cycle, with input tready low; cfg writes are taken.
module keyed_reading_aggregator_top
  import kra_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,  // text_byte, read_index, zero pad
  input  logic                s_axis_tuser_i,  // mode
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [M_DATA_W-1:0] m_axis_tdata_o,  // entry_index, count, sum, min, max, pad
  output logic                m_axis_tuser_o,  // kind
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [HASH_W-1:0]   cfg_data_i
);

  logic [HASH_W-1:0] hash_base_q;

  logic                  clearing_q;
  logic [INDEX_BITS-1:0] clr_addr_q;

  logic              s1_valid_q;
  logic              s1_mode_q;
  logic [BYTE_W-1:0] s1_byte_q;
  logic [RIDX_W-1:0] s1_ridx_q;

  logic                  phase_q, phase_d;
  logic [HASH_W-1:0]     hash_q, hash_d;
  logic [INDEX_BITS-1:0] sel_q, sel_d;
  logic [ACC_W-1:0]      acc_q, acc_d;
  logic                  neg_q, neg_d;

  logic                    s2_valid_q;
  logic                    s2_kind_q;
  logic [INDEX_BITS-1:0]   s2_idx_q;
  logic signed [EXT_W-1:0] s2_val_q;

  entry_t mem_q [TABLE_SIZE];
  entry_t rd_q;

  logic                  fwd_valid_q;
  logic [INDEX_BITS-1:0] fwd_idx_q;
  entry_t                fwd_data_q;

  logic                m_valid_q;
  logic                m_kind_q;
  logic [M_DATA_W-1:0] m_data_q;

  logic pipe_en;
  logic s_accept;
  logic s1_go;

  logic                    op_valid;
  logic                    op_kind;
  logic [INDEX_BITS-1:0]   op_addr;
  logic signed [EXT_W-1:0] op_val;

  logic [INDEX_BITS+RIDX_W-1:0] ridx_ext;
  logic [ACCX_W-1:0]            acc_wide;
  logic [ACCX_W-1:0]            acc_ext;
  logic [3:0]                   digit;
  logic signed [EXT_W-1:0]      val_pos;
  logic [BYTE_W-1:0]            digit_off;

  entry_t                  old_e;
  entry_t                  new_e;
  entry_t                  res_e;
  logic signed [SUM_W:0]   sum_wide;
  logic                    upd_we;
  logic [INDEX_BITS+RIDX_W-1:0] s2_idx_ext;

  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_waddr;
  entry_t                mem_wdata;

  assign pipe_en         = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !clearing_q && (!s1_valid_q || pipe_en);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign s1_go           = s1_valid_q && pipe_en;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_base_q <= HASH_BASE_RESET;
    end else if (cfg_valid_i) begin
      hash_base_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == {INDEX_BITS{1'b1}}) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // stage 1: input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_valid_q || pipe_en) begin
      s1_valid_q <= s_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_mode_q <= s_axis_tuser_i;
      s1_byte_q <= s_axis_tdata_i[BYTE_W-1:0];
      s1_ridx_q <= s_axis_tdata_i[BYTE_W +: RIDX_W];
    end
  end

  // line parser
  assign ridx_ext  = {{INDEX_BITS{1'b0}}, s1_ridx_q};
  assign digit_off = s1_byte_q - CHAR_ZERO;
  assign digit     = digit_off[3:0];
  assign acc_ext   = {{(ACCX_W - ACC_W){1'b0}}, acc_q};
  assign acc_wide  = (acc_ext << 3) + (acc_ext << 1) + {{(ACCX_W - 4){1'b0}}, digit};
  assign val_pos   = $signed({{(EXT_W - ACC_W){1'b0}}, acc_q});

  always_comb begin
    phase_d  = phase_q;
    hash_d   = hash_q;
    sel_d    = sel_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    op_valid = 1'b0;
    op_kind  = KIND_UPDATE;
    op_addr  = sel_q;
    op_val   = neg_q ? -val_pos : val_pos;
    if (s1_valid_q) begin
      if (s1_mode_q == MODE_READ) begin
        op_valid = 1'b1;
        op_kind  = KIND_READ;
        op_addr  = ridx_ext[INDEX_BITS-1:0];
      end else if (!phase_q) begin
        if (s1_byte_q == CHAR_SEMI) begin
          sel_d   = hash_q[HASH_W-1 -: INDEX_BITS];
          phase_d = 1'b1;
        end else if (s1_byte_q == CHAR_NL) begin
          hash_d = '0;
          acc_d  = '0;
          neg_d  = 1'b0;
        end else begin
          hash_d = hash_q * hash_base_q + {{(HASH_W - BYTE_W){1'b0}}, s1_byte_q};
        end
      end else begin
        if (s1_byte_q == CHAR_MINUS) begin
          neg_d = 1'b1;
        end else if (s1_byte_q inside {[CHAR_ZERO:CHAR_NINE]}) begin
          acc_d = (acc_wide > {{(ACCX_W - ACC_W){1'b0}}, ACC_MAX}) ? ACC_MAX
                                                                   : acc_wide[ACC_W-1:0];
        end else if (s1_byte_q == CHAR_NL) begin
          op_valid = 1'b1;
          phase_d  = 1'b0;
          hash_d   = '0;
          acc_d    = '0;
          neg_d    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      hash_q  <= '0;
      sel_q   <= '0;
      acc_q   <= '0;
      neg_q   <= 1'b0;
    end else if (s1_go) begin
      phase_q <= phase_d;
      hash_q  <= hash_d;
      sel_q   <= sel_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
    end
  end

  // stage 2: table read data and update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s2_valid_q <= s1_valid_q && op_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && op_valid) begin
      s2_kind_q <= op_kind;
      s2_idx_q  <= op_addr;
      s2_val_q  <= op_val;
    end
  end

  assign old_e = (fwd_valid_q && fwd_idx_q == s2_idx_q) ? fwd_data_q : rd_q;

  assign sum_wide = {old_e.sum[SUM_W-1], old_e.sum}
                  + {{(SUM_W - EXT_W + 1){s2_val_q[EXT_W-1]}}, s2_val_q};

  always_comb begin
    new_e.count = (old_e.count == CNT_MAX) ? old_e.count : old_e.count + 1'b1;
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      new_e.sum = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      new_e.sum = sum_wide[SUM_W-1:0];
    end
    new_e.min = (s2_val_q < old_e.min) ? s2_val_q : old_e.min;
    new_e.max = (s2_val_q > old_e.max) ? s2_val_q : old_e.max;
  end

  assign upd_we     = pipe_en && s2_valid_q && (s2_kind_q == KIND_UPDATE);
  assign res_e      = (s2_kind_q == KIND_UPDATE) ? new_e : old_e;
  assign s2_idx_ext = {{RIDX_W{1'b0}}, s2_idx_q};

  assign mem_we    = clearing_q || upd_we;
  assign mem_waddr = clearing_q ? clr_addr_q : s2_idx_q;
  assign mem_wdata = clearing_q ? ENTRY_RESET : new_e;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (s1_go && op_valid) begin
      rd_q <= mem_q[op_addr];
    end
  end

  // write issued alongside a read lands after that read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (pipe_en) begin
      fwd_valid_q <= upd_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_we) begin
      fwd_idx_q  <= s2_idx_q;
      fwd_data_q <= new_e;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (pipe_en) begin
      m_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en && s2_valid_q) begin
      m_kind_q <= s2_kind_q;
      m_data_q <= {{M_PAD_W{1'b0}}, res_e.max, res_e.min, res_e.sum, res_e.count,
                   s2_idx_ext[RIDX_W-1:0]};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule
